// File: rtl/ps2_framed_receiver_defines.svh
// Assertion macros used by the receiver's frame engine.
`ifndef PS2_FRAMED_RECEIVER_DEFINES_SVH
`define PS2_FRAMED_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PS2FR_ASSERT_IMPL(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PS2FR_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/ps2fr_pkg.sv
package ps2fr_pkg;

    // Frame length default and the number of byte fields in a result.
    localparam int FRAME_BYTES_DEF = 4;
    localparam int OUT_BYTES       = 4;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LIMIT = 2'd1;
    localparam logic [15:0] FRAME_GAP_RESET = 16'd2000;
    localparam logic [15:0] BIT_LIMIT_RESET = 16'd620;

    // Bit positions inside one 11-bit PS/2 byte.
    localparam logic [3:0] POS_START      = 4'd0;
    localparam logic [3:0] POS_DATA_FIRST = 4'd1;
    localparam logic [3:0] POS_DATA_LAST  = 4'd8;
    localparam logic [3:0] POS_PARITY     = 4'd9;
    localparam logic [3:0] POS_STOP       = 4'd10;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_START   = 3'd1,
        ST_PARITY  = 3'd2,
        ST_STOP    = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    // Result of one edge as seen by the result register.
    typedef struct packed {
        logic                      produce;
        status_t                   status;
        logic [OUT_BYTES-1:0][7:0] bytes;
    } result_t;

endpackage

// File: rtl/ps2fr_frame_engine.sv
`include "ps2_framed_receiver_defines.svh"

module ps2fr_frame_engine #(
    parameter int FRAME_BYTES = ps2fr_pkg::FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rstn,
    input  logic                fire,
    input  logic                data_bit,
    input  logic [15:0]         gap_us,
    input  logic [15:0]         frame_gap_us,
    input  logic [15:0]         bit_gap_limit_us,
    output ps2fr_pkg::result_t  res
);

    localparam int CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(FRAME_BYTES - 1);

    logic             in_frame_reg, in_frame_next;
    logic [3:0]       bit_position_reg, bit_position_next;
    logic [7:0]       shift_byte_reg, shift_byte_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       frame_store [FRAME_BYTES];

    logic             start;
    logic [3:0]       pos;
    logic [7:0]       sb;
    logic [CNT_W-1:0] bc;
    logic [3:0]       pos_m1;
    logic             err;
    logic             done;
    logic             store_wr;
    ps2fr_pkg::status_t status;
    logic [ps2fr_pkg::OUT_BYTES-1:0][7:0] done_bytes;

    // Step the frame state for the item in the input register.
    always_comb begin
        start             = !in_frame_reg;
        pos               = start ? ps2fr_pkg::POS_START : bit_position_reg;
        sb                = start ? 8'd0 : shift_byte_reg;
        bc                = start ? '0 : byte_count_reg;
        pos_m1            = pos - 4'd1;
        in_frame_next     = in_frame_reg;
        bit_position_next = bit_position_reg;
        shift_byte_next   = shift_byte_reg;
        byte_count_next   = byte_count_reg;
        err               = 1'b0;
        done              = 1'b0;
        store_wr          = 1'b0;
        status            = ps2fr_pkg::ST_DONE;

        if (start && (gap_us < frame_gap_us)) begin
            // ignore edges while searching for a frame
        end else if (!start && (gap_us > bit_gap_limit_us)) begin
            err    = 1'b1;
            status = ps2fr_pkg::ST_TIMEOUT;
        end else begin
            in_frame_next     = 1'b1;
            bit_position_next = pos;
            shift_byte_next   = sb;
            byte_count_next   = bc;
            case (pos)
                ps2fr_pkg::POS_START: begin
                    if (data_bit) begin
                        err    = 1'b1;
                        status = ps2fr_pkg::ST_START;
                    end else begin
                        bit_position_next = ps2fr_pkg::POS_DATA_FIRST;
                    end
                end
                ps2fr_pkg::POS_PARITY: begin
                    if (!((^sb) ^ data_bit)) begin
                        err    = 1'b1;
                        status = ps2fr_pkg::ST_PARITY;
                    end else begin
                        bit_position_next = ps2fr_pkg::POS_STOP;
                    end
                end
                ps2fr_pkg::POS_STOP: begin
                    if (!data_bit) begin
                        err    = 1'b1;
                        status = ps2fr_pkg::ST_STOP;
                    end else begin
                        store_wr          = 1'b1;
                        bit_position_next = ps2fr_pkg::POS_START;
                        shift_byte_next   = 8'd0;
                        if (bc == LAST_BYTE) begin
                            done            = 1'b1;
                            in_frame_next   = 1'b0;
                            byte_count_next = '0;
                        end else begin
                            byte_count_next = bc + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    if ((pos >= ps2fr_pkg::POS_DATA_FIRST) &&
                        (pos <= ps2fr_pkg::POS_DATA_LAST)) begin
                        shift_byte_next   = sb | (8'(data_bit) << pos_m1[2:0]);
                        bit_position_next = pos + 4'd1;
                    end else begin
                        err    = 1'b1;
                        status = ps2fr_pkg::ST_START;
                    end
                end
            endcase
        end

        // Drop the frame on any error.
        if (err) begin
            in_frame_next     = 1'b0;
            bit_position_next = ps2fr_pkg::POS_START;
            shift_byte_next   = 8'd0;
            byte_count_next   = '0;
        end
    end

    // Gather the frame bytes; the last byte comes straight from the shifter.
    for (genvar j = 0; j < ps2fr_pkg::OUT_BYTES; j++) begin : g_bytes
        if (j < FRAME_BYTES - 1) begin : g_store
            assign done_bytes[j] = frame_store[CNT_W'(j)];
        end else if (j == FRAME_BYTES - 1) begin : g_last
            assign done_bytes[j] = sb;
        end else begin : g_zero
            assign done_bytes[j] = 8'd0;
        end
    end

    always_comb begin
        res.produce = err || done;
        res.status  = status;
        res.bytes   = done ? done_bytes : '0;
    end

    // Advance frame state on each processed beat.
    always_ff @(posedge clk) begin
        if (!rstn) begin
            in_frame_reg     <= 1'b0;
            bit_position_reg <= ps2fr_pkg::POS_START;
            shift_byte_reg   <= 8'd0;
            byte_count_reg   <= '0;
        end else if (fire) begin
            in_frame_reg     <= in_frame_next;
            bit_position_reg <= bit_position_next;
            shift_byte_reg   <= shift_byte_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    // Hold finished bytes of the current frame.
    always_ff @(posedge clk) begin
        if (fire && store_wr) begin
            frame_store[bc] <= sb;
        end
    end

    `PS2FR_ASSERT_IMPL(a_idle_clear, clk, rstn, !in_frame_reg,
        (bit_position_reg == 4'd0) && (shift_byte_reg == 8'd0) && (byte_count_reg == '0),
        "frame state not cleared outside a frame")
    `PS2FR_ASSERT_IMPL(a_done_at_stop, clk, rstn,
        fire && res.produce && (res.status == ps2fr_pkg::ST_DONE),
        in_frame_reg && (bit_position_reg == ps2fr_pkg::POS_STOP) && data_bit,
        "frame done outside a good stop bit")
    `PS2FR_ASSERT_NEXT(a_result_closes, clk, rstn, fire && res.produce, !in_frame_reg,
        "frame still open after a result")
    `PS2FR_ASSERT_IMPL(a_count_range, clk, rstn, in_frame_reg, byte_count_reg <= LAST_BYTE,
        "byte count past frame length")

endmodule

// File: rtl/ps2fr_result_reg.sv
module ps2fr_result_reg (
    input  logic               clk,
    input  logic               rstn,
    input  logic               load,
    input  ps2fr_pkg::result_t res,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_byte0,
    output logic [7:0]         m_byte1,
    output logic [7:0]         m_byte2,
    output logic [7:0]         m_byte3
);

    logic                 m_valid_reg, m_valid_next;
    ps2fr_pkg::status_t   status_reg;
    logic [ps2fr_pkg::OUT_BYTES-1:0][7:0] bytes_reg;

    // Set on load, clear when the beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the payload with the load.
    always_ff @(posedge clk) begin
        if (load) begin
            status_reg <= res.status;
            bytes_reg  <= res.bytes;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_byte0  = bytes_reg[0];
    assign m_byte1  = bytes_reg[1];
    assign m_byte2  = bytes_reg[2];
    assign m_byte3  = bytes_reg[3];

endmodule

// File: rtl/ps2_framed_receiver.sv
// An accepted edge is stepped from the input register, and its result beat, if any,
// is loaded into the result register that drives m_valid.
// Throughput: one edge per cycle, set by the single input register feeding the
// frame step logic; it stalls only while the held edge makes a result and the
// previous result beat still waits on m_ready.
// Reset: synchronous, active-low aresetn clears the frame search and the
// valid flags and loads the gap registers with 2000 us and 620 us.
module ps2_framed_receiver #(
    parameter int FRAME_BYTES = ps2fr_pkg::FRAME_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ps2fr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_data_bit,
    input  logic [15:0]                   s_gap_us,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [7:0]                    m_byte0,
    output logic [7:0]                    m_byte1,
    output logic [7:0]                    m_byte2,
    output logic [7:0]                    m_byte3
);

    logic        in_valid_reg, in_valid_next;
    logic        data_bit_reg;
    logic [15:0] gap_us_reg;
    logic [15:0] frame_gap_reg;
    logic [15:0] bit_limit_reg;
    logic        advance;
    ps2fr_pkg::result_t res;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_gap_reg <= ps2fr_pkg::FRAME_GAP_RESET;
            bit_limit_reg <= ps2fr_pkg::BIT_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                ps2fr_pkg::CFG_FRAME_GAP: frame_gap_reg <= cfg_wdata;
                ps2fr_pkg::CFG_BIT_LIMIT: bit_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the held edge unless its result would hit a full output slot.
    assign advance = in_valid_reg && (!res.produce || !m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the input beat.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_bit_reg <= s_data_bit;
            gap_us_reg   <= s_gap_us;
        end
    end

    ps2fr_frame_engine #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_engine (
        .clk              (aclk),
        .rstn             (aresetn),
        .fire             (advance),
        .data_bit         (data_bit_reg),
        .gap_us           (gap_us_reg),
        .frame_gap_us     (frame_gap_reg),
        .bit_gap_limit_us (bit_limit_reg),
        .res              (res)
    );

    ps2fr_result_reg u_result (
        .clk      (aclk),
        .rstn     (aresetn),
        .load     (advance && res.produce),
        .res      (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_byte0  (m_byte0),
        .m_byte1  (m_byte1),
        .m_byte2  (m_byte2),
        .m_byte3  (m_byte3)
    );

endmodule

// File: test/testbench.sv
module testbench;

    localparam int CLK_PERIOD    = 12;
    localparam int FRAME_LEN     = ps2fr_pkg::FRAME_BYTES_DEF;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_CYCLES = 400000;

    // Indexes past the last register; writes there must be ignored.
    localparam logic [ps2fr_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ps2fr_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {
        FLT_NONE,
        FLT_START,
        FLT_PARITY,
        FLT_STOP,
        FLT_TIMEOUT,
        FLT_CUT
    } fault_t;

    typedef struct packed {
        ps2fr_pkg::status_t                   status;
        logic [ps2fr_pkg::OUT_BYTES-1:0][7:0] bytes;
    } frame_beat_t;

    typedef struct packed {
        logic        data;
        logic [15:0] gap;
    } edge_t;

    // Decode falling edges into frames and match result beats in order.
    class ps2_frame_scoreboard;
        logic [15:0] frame_gap;
        logic [15:0] bit_limit;
        bit          open_frame;
        logic [3:0]  bit_pos;
        logic [7:0]  shift_reg;
        int unsigned byte_idx;
        logic [7:0]  byte_store [FRAME_LEN];
        frame_beat_t pending_frames [$];
        int          mismatches;

        function new();
            frame_gap  = ps2fr_pkg::FRAME_GAP_RESET;
            bit_limit  = ps2fr_pkg::BIT_LIMIT_RESET;
            open_frame = 1'b0;
            bit_pos    = ps2fr_pkg::POS_START;
            shift_reg  = '0;
            byte_idx   = 0;
            mismatches = 0;
            foreach (byte_store[i]) byte_store[i] = '0;
        endfunction

        function void write_reg(logic [ps2fr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                ps2fr_pkg::CFG_FRAME_GAP: frame_gap = value;
                ps2fr_pkg::CFG_BIT_LIMIT: bit_limit = value;
                default: ;
            endcase
        endfunction

        // Close the frame and queue the beat it produces.
        function void close_frame(ps2fr_pkg::status_t code);
            frame_beat_t beat;
            beat.status = code;
            beat.bytes  = '0;
            if (code == ps2fr_pkg::ST_DONE) begin
                for (int j = 0; j < ps2fr_pkg::OUT_BYTES; j++) begin
                    if (j < FRAME_LEN) beat.bytes[j] = byte_store[j];
                end
            end
            open_frame = 1'b0;
            bit_pos    = ps2fr_pkg::POS_START;
            shift_reg  = '0;
            byte_idx   = 0;
            pending_frames.push_back(beat);
        endfunction

        function void note_edge(logic data, logic [15:0] gap_in);
            logic [15:0] gap;
            gap = gap_in;
            // Search for a frame: only a long enough gap opens one.
            if (!open_frame) begin
                if (gap < frame_gap) return;
                open_frame = 1'b1;
                byte_idx   = 0;
                bit_pos    = ps2fr_pkg::POS_START;
                shift_reg  = '0;
                gap        = '0;
            end
            if (gap > bit_limit) begin
                close_frame(ps2fr_pkg::ST_TIMEOUT);
                return;
            end
            if (bit_pos == ps2fr_pkg::POS_START) begin
                if (data) close_frame(ps2fr_pkg::ST_START);
                else bit_pos = ps2fr_pkg::POS_DATA_FIRST;
            end else if (bit_pos <= ps2fr_pkg::POS_DATA_LAST) begin
                shift_reg[bit_pos - ps2fr_pkg::POS_DATA_FIRST] = data;
                bit_pos++;
            end else if (bit_pos == ps2fr_pkg::POS_PARITY) begin
                if ((^shift_reg ^ data) == 1'b0) close_frame(ps2fr_pkg::ST_PARITY);
                else bit_pos = ps2fr_pkg::POS_STOP;
            end else if (bit_pos == ps2fr_pkg::POS_STOP) begin
                if (!data) begin
                    close_frame(ps2fr_pkg::ST_STOP);
                end else begin
                    byte_store[byte_idx] = shift_reg;
                    bit_pos   = ps2fr_pkg::POS_START;
                    shift_reg = '0;
                    if (byte_idx + 1 >= FRAME_LEN) close_frame(ps2fr_pkg::ST_DONE);
                    else byte_idx++;
                end
            end else begin
                close_frame(ps2fr_pkg::ST_START);
            end
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_beat(logic [2:0] status, logic [7:0] b0, logic [7:0] b1,
                        logic [7:0] b2, logic [7:0] b3);
            frame_beat_t want;
            logic [7:0]  got [ps2fr_pkg::OUT_BYTES];
            got = '{b0, b1, b2, b3};
            if (pending_frames.size() == 0) begin
                report($sformatf("result beat with none expected, status %0d", status));
                return;
            end
            want = pending_frames.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
            for (int j = 0; j < ps2fr_pkg::OUT_BYTES; j++) begin
                if (got[j] !== want.bytes[j])
                    report($sformatf("byte%0d 0x%02h, expected 0x%02h", j, got[j],
                                     want.bytes[j]));
            end
        endtask

        function int pending_count();
            return pending_frames.size();
        endfunction

        task close_out();
            if (pending_frames.size() != 0)
                report($sformatf("%0d result beats never arrived", pending_frames.size()));
        endtask
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [ps2fr_pkg::CFG_IDX_W-1:0]     cfg_addr;
    logic [15:0]                         cfg_wdata;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_data_bit;
    logic [15:0]                         s_gap_us;
    logic                                m_valid;
    logic                                m_ready;
    logic [2:0]                          m_status;
    logic [7:0]                          m_byte0;
    logic [7:0]                          m_byte1;
    logic [7:0]                          m_byte2;
    logic [7:0]                          m_byte3;

    ps2_frame_scoreboard sb;
    edge_t               edge_q [$];
    logic [15:0]         cur_frame_gap;
    logic [15:0]         cur_bit_limit;
    bit                  hold_req;

    ps2_framed_receiver i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_bit (s_data_bit),
        .s_gap_us   (s_gap_us),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_byte0    (m_byte0),
        .m_byte1    (m_byte1),
        .m_byte2    (m_byte2),
        .m_byte3    (m_byte3)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watch every handshake at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_wdata);
            if (m_valid && m_ready)
                sb.check_beat(m_status, m_byte0, m_byte1, m_byte2, m_byte3);
            if (s_valid && s_ready) sb.note_edge(s_data_bit, s_gap_us);
        end
    end

    // Stall the result side on a changing pattern; hold off long on request.
    initial begin
        int mode;
        int left;
        int tick;
        mode    = 0;
        left    = 0;
        tick    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(3);
                    left = $urandom_range(300, 50);
                end
                left--;
                tick++;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(1));
                    2:       m_ready <= ($urandom_range(9) != 0);
                    default: m_ready <= ((tick % 7) >= 3);
                endcase
            end
        end
    end

    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("FAIL ps2_framed_receiver");
        $finish;
    end

    function automatic logic [15:0] open_gap();
        if ($urandom_range(3) == 0) return cur_frame_gap;
        return 16'($urandom_range(65535, int'(cur_frame_gap)));
    endfunction

    function automatic logic [15:0] bit_gap();
        case ($urandom_range(7))
            0:       return cur_bit_limit;
            1:       return '0;
            default: return 16'($urandom_range(int'(cur_bit_limit)));
        endcase
    endfunction

    function automatic logic [15:0] late_gap();
        return 16'($urandom_range(65535, int'(cur_bit_limit) + 1));
    endfunction

    // Queue one frame of edges, optionally broken at one byte.
    function automatic void add_frame(fault_t fault, int fault_byte);
        logic [7:0]  value;
        logic [10:0] bits;
        logic [15:0] g;
        int          last;
        int          late_at;
        for (int k = 0; k < FRAME_LEN; k++) begin
            value   = 8'($urandom);
            bits    = {1'b1, ~^value, value, 1'b0};
            last    = 10;
            late_at = -1;
            if (k == fault_byte) begin
                case (fault)
                    FLT_START: begin
                        bits[0] = 1'b1;
                        last    = 0;
                    end
                    FLT_PARITY: begin
                        bits[9] = ~bits[9];
                        last    = 9;
                    end
                    FLT_STOP:  bits[10] = 1'b0;
                    FLT_TIMEOUT: begin
                        late_at = (k == 0) ? $urandom_range(10, 1) : $urandom_range(10, 0);
                        last    = late_at;
                    end
                    FLT_CUT:   last = $urandom_range(9, 0);
                    default: ;
                endcase
            end
            for (int b = 0; b <= last; b++) begin
                if (k == 0 && b == 0) g = open_gap();
                else if (b == late_at) g = late_gap();
                else g = bit_gap();
                edge_q.push_back('{bits[b], g});
            end
            if (k == fault_byte && fault != FLT_NONE) return;
        end
    endfunction

    // Queue edges that mostly fall outside any frame.
    function automatic void add_noise(int n);
        logic [15:0] g;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1) && cur_frame_gap != 0)
                g = 16'($urandom_range(int'(cur_frame_gap) - 1));
            else
                g = 16'($urandom_range(65535));
            edge_q.push_back('{1'($urandom_range(1)), g});
        end
    endfunction

    task automatic cfg_write(logic [ps2fr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Send queued edges in bursts with random gaps between them.
    task automatic drive_edges();
        edge_t item;
        int    burst;
        int    idle;
        while (edge_q.size() > 0) begin
            burst = $urandom_range(50, 1);
            while (burst > 0 && edge_q.size() > 0) begin
                item = edge_q.pop_front();
                @(negedge aclk);
                s_valid    <= 1'b1;
                s_data_bit <= item.data;
                s_gap_us   <= item.gap;
                do @(posedge aclk); while (!s_ready);
                burst--;
            end
            idle = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(12);
            if (idle > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (idle - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Wait for every expected beat, then let the pipeline settle.
    task automatic wait_drain();
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(bit write_cfg, logic [15:0] fg, logic [15:0] lim,
                             int n_items, bit hold);
        int     count;
        int     before_sz;
        int     pick;
        fault_t fault;
        if (write_cfg) begin
            cfg_write(ps2fr_pkg::CFG_FRAME_GAP, fg);
            cfg_write(ps2fr_pkg::CFG_BIT_LIMIT, lim);
            cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
            cur_frame_gap = fg;
            cur_bit_limit = lim;
        end
        count = 0;
        while (count < n_items) begin
            before_sz = edge_q.size();
            pick = $urandom_range(99);
            if (pick < 70) begin
                case ($urandom_range(9))
                    6:       fault = FLT_START;
                    7:       fault = FLT_PARITY;
                    8:       fault = FLT_STOP;
                    9:       fault = (cur_bit_limit != 16'hFFFF) ? FLT_TIMEOUT : FLT_NONE;
                    default: fault = FLT_NONE;
                endcase
                add_frame(fault, $urandom_range(FRAME_LEN - 1));
                count += edge_q.size() - before_sz;
            end else if (pick < 85) begin
                add_noise($urandom_range(6, 1));
            end else if (pick < 95) begin
                add_frame(FLT_CUT, $urandom_range(FRAME_LEN - 1));
                count += edge_q.size() - before_sz;
            end else begin
                for (int i = $urandom_range(4, 1); i > 0; i--)
                    edge_q.push_back('{1'($urandom_range(1)), 16'($urandom)});
                count += edge_q.size() - before_sz;
            end
        end
        if (hold) hold_req = 1'b1;
        drive_edges();
        wait_drain();
    endtask

    initial begin
        sb            = new();
        hold_req      = 1'b0;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_addr      = ps2fr_pkg::CFG_FRAME_GAP;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data_bit    = 1'b0;
        s_gap_us      = '0;
        cur_frame_gap = ps2fr_pkg::FRAME_GAP_RESET;
        cur_bit_limit = ps2fr_pkg::BIT_LIMIT_RESET;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored edge, start error at the exact frame gap,
        // timeout one past the limit, parity error, stop error.
        edge_q.push_back('{1'b1, 16'd1999});
        edge_q.push_back('{1'b1, 16'd2000});
        edge_q.push_back('{1'b0, 16'hFFFF});
        edge_q.push_back('{1'b0, 16'd621});
        edge_q.push_back('{1'b0, 16'd2000});
        repeat (8) edge_q.push_back('{1'b1, 16'd620});
        edge_q.push_back('{1'b0, 16'd620});
        edge_q.push_back('{1'b0, 16'd40000});
        repeat (8) edge_q.push_back('{1'b0, 16'd0});
        edge_q.push_back('{1'b1, 16'd0});
        edge_q.push_back('{1'b0, 16'd0});
        drive_edges();
        wait_drain();

        // Random phases across register settings, extremes included.
        run_phase(1'b0, ps2fr_pkg::FRAME_GAP_RESET, ps2fr_pkg::BIT_LIMIT_RESET, 300, 1'b0);
        run_phase(1'b1, 16'd0, 16'hFFFF, 200, 1'b0);
        run_phase(1'b1, 16'hFFFF, 16'd0, 200, 1'b0);
        run_phase(1'b1, 16'd150, 16'd400, 300, 1'b1);
        run_phase(1'b1, 16'($urandom), 16'($urandom), 250, 1'b0);
        run_phase(1'b1, ps2fr_pkg::FRAME_GAP_RESET, ps2fr_pkg::BIT_LIMIT_RESET, 250, 1'b0);

        sb.close_out();
        if (sb.mismatches == 0) begin
            $display("PASS ps2_framed_receiver");
        end else begin
            $display("FAIL ps2_framed_receiver");
        end
        $finish;
    end

endmodule
